// ----- src/assert_macros.svh -----
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)

`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// ----- src/ile_pkg.sv -----
package ile_pkg;

  localparam int unsigned IDX_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADIDX = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SHIFT  = 2'd1,
    S_RDWAIT = 2'd2,
    S_EMIT   = 2'd3
  } state_t;

endpackage

// ----- src/ile_ram.sv -----
module ile_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/indexed_list_engine.sv -----
// Channel | Dir | tdata (low bit up)                  | tuser
// in_     | in  | index[6:0], value[38:7], pad [39]   | kind[1:0]
// out_    | out | read_value[31:0], count[38:32], pad | status[1:0]
//
// Entries sit in one single-port-write RAM; insert and delete move one entry
// per cycle through it (read, then write one slot over).
// Insert shifts entries from the tail down to index, then writes the value at
// index; delete shifts the entries above index down. A read waits in S_RDWAIT;
// rejected operations go straight to S_EMIT. A new transfer is taken only in idle.
// rst_n (sync) clears the count and control; RAM contents are not cleared.
// A result held by out_tready low stalls the engine only at its final step.
`include "assert_macros.svh"

module indexed_list_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ile_pkg::IN_TDATA_W-1:0]       in_tdata,   // index, value
  input  logic [ile_pkg::KIND_W-1:0]           in_tuser,   // kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ile_pkg::OUT_TDATA_W-1:0]      out_tdata,  // read_value, count
  output logic [ile_pkg::STAT_W-1:0]           out_tuser   // status
);

  import ile_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [AW-1:0]    last_r, last_nxt;
  logic             pend_r, pend_nxt;
  logic             ins_r, ins_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] res_value_r, res_value_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [CW-1:0]    res_count_r, res_count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0]      out_tuser_r, out_tuser_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  logic             in_xfer;
  kind_t            in_kind;
  logic [XW-1:0]    idx_x, cnt_x;
  logic [VAL_W-1:0] in_value;
  logic             full, out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_kind   = kind_t'(in_tuser);
  assign idx_x     = XW'(in_tdata[IDX_W-1:0]);
  assign cnt_x     = XW'(count_r);
  assign in_value  = in_tdata[IDX_W +: VAL_W];
  assign full      = (count_r == CW'(CAPACITY));
  assign out_free  = !out_valid_r || out_tready;

  ile_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    last_r       <= last_nxt;
    ins_r        <= ins_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    src_nxt        = src_r;
    last_nxt       = last_r;
    pend_nxt       = 1'b0;
    ins_nxt        = ins_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = val_r;
    ram_re         = 1'b0;
    ram_raddr      = src_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          pos_nxt        = idx_x[AW-1:0];
          val_nxt        = in_value;
          res_value_nxt  = '0;
          res_status_nxt = STAT_OK;
          res_count_nxt  = count_r;
          state_nxt      = S_EMIT;
          case (in_kind)
            KIND_INSERT: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else if (idx_x > cnt_x) begin
                res_status_nxt = STAT_BADIDX;
              end else begin
                ins_nxt       = 1'b1;
                count_nxt     = count_r + 1'b1;
                res_count_nxt = count_r + 1'b1;
                left_nxt      = CW'(cnt_x - idx_x);
                src_nxt       = AW'(count_r - 1'b1);
                state_nxt     = S_SHIFT;
              end
            end
            KIND_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else if (idx_x >= cnt_x) begin
                res_status_nxt = STAT_BADIDX;
              end else begin
                ins_nxt       = 1'b0;
                count_nxt     = count_r - 1'b1;
                res_count_nxt = count_r - 1'b1;
                left_nxt      = CW'(cnt_x - idx_x - 1'b1);
                src_nxt       = AW'(idx_x + 1'b1);
                state_nxt     = S_SHIFT;
              end
            end
            KIND_READ: begin
              if (idx_x >= cnt_x) begin
                res_status_nxt = STAT_BADIDX;
                res_value_nxt  = '1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_x[AW-1:0];
                state_nxt = S_RDWAIT;
              end
            end
            default: begin
              res_status_nxt = STAT_BADIDX;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (left_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_r;
          pend_nxt  = 1'b1;
          last_nxt  = src_r;
          left_nxt  = left_r - 1'b1;
          src_nxt   = ins_r ? src_r - 1'b1 : src_r + 1'b1;
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = ins_r ? last_r + 1'b1 : last_r - 1'b1;
          ram_wdata = ram_rdata;
        end else if (left_r == '0) begin
          ram_we    = ins_r;
          ram_waddr = pos_r;
          ram_wdata = val_r;
          state_nxt = S_EMIT;
        end
      end
      S_RDWAIT: begin
        res_value_nxt = ram_rdata;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {1'b0, IDX_W'(res_count_r), res_value_r};
          out_tuser_nxt = res_status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_r <= CW'(CAPACITY), "count above capacity")
  `ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "shift read and write hit one entry")
  `ASSERT_NEXT(a_read_keeps_count, clk, rst_n, in_xfer && (in_tuser == KIND_READ), count_r == $past(count_r), "read changed count")
  `ASSERT_ALWAYS(a_write_in_shift, clk, rst_n, !ram_we || (state_r == S_SHIFT), "RAM write outside shift")

endmodule
